>>> design/jets_pkg.sv
// ----------------------------------------------------------------------------
// jets_pkg
// Shared types, constants and the log-scale level table for the Julia set
// escape-time pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package jets_pkg;

  // fixed field widths of the pixel and result words
  localparam int PIX_W         = 12;
  localparam int ITER_W        = 6;
  localparam int LEVEL_W       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int LEVEL_ENTRIES = 33;
  localparam int LEVEL_IDX_W   = 6;

  // reset values, given with 20 fraction bits and rescaled to the word format
  localparam int     RST_FRAC_BITS = 20;
  localparam longint RST_X_ORIGIN  = -2097152;
  localparam longint RST_Y_ORIGIN  = -1048576;
  localparam longint RST_X_STEP    = 6991;
  localparam longint RST_Y_STEP    = 6991;
  localparam longint RST_C_REAL    = -875561;
  localparam longint RST_C_IMAG    = -243376;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_C_REAL   = 3'd4,
    REG_C_IMAG   = 3'd5
  } cfg_reg_t;

  typedef logic [LEVEL_W-1:0] level_t;

  // floor(255*ln(1+it)/ln(33))
  localparam level_t LEVEL_TABLE [LEVEL_ENTRIES] = '{
    8'd0,   8'd50,  8'd80,  8'd101, 8'd117, 8'd130, 8'd141, 8'd151, 8'd160,
    8'd167, 8'd174, 8'd181, 8'd187, 8'd192, 8'd197, 8'd202, 8'd206, 8'd210,
    8'd214, 8'd218, 8'd222, 8'd225, 8'd228, 8'd231, 8'd234, 8'd237, 8'd240,
    8'd243, 8'd245, 8'd248, 8'd250, 8'd252, 8'd255
  };

  // controller to datapath commands
  typedef struct packed {
    logic load;     // latch the pixel word
    logic map_mul;  // index times step products
    logic map_add;  // origin add, start point, clear count
    logic square;   // register re*re, im*im, re*im
    logic step;     // write z^2 + c and bump the count
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic escape;   // |z|^2 >= 4 on the registered products
    logic last;     // count is one short of the limit
  } status_t;

  // table lookup, counts past the end read the last entry
  function automatic level_t level_of(input logic [7:0] it);
    if (it >= 8'(LEVEL_ENTRIES - 1)) begin
      return LEVEL_TABLE[LEVEL_ENTRIES-1];
    end
    return LEVEL_TABLE[it[LEVEL_IDX_W-1:0]];
  endfunction

  // move a reset constant to another number of fraction bits
  function automatic longint scale_reset(input longint v, input int frac);
    if (frac >= RST_FRAC_BITS) begin
      return v <<< (frac - RST_FRAC_BITS);
    end
    return v >>> (RST_FRAC_BITS - frac);
  endfunction

endpackage

`default_nettype wire

>>> design/jets_cfg.sv
// ----------------------------------------------------------------------------
// jets_cfg
// Configuration register file: window origin, step and Julia constant.
// ----------------------------------------------------------------------------
`default_nettype none

module jets_cfg
  import jets_pkg::*;
#(
  parameter int WORD_BITS = 24,
  parameter int FRAC_BITS = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [WORD_BITS-1:0]        cfg_data,
  output logic signed [WORD_BITS-1:0]      x_origin,
  output logic signed [WORD_BITS-1:0]      y_origin,
  output logic signed [WORD_BITS-1:0]      x_step,
  output logic signed [WORD_BITS-1:0]      y_step,
  output logic signed [WORD_BITS-1:0]      c_real,
  output logic signed [WORD_BITS-1:0]      c_imag
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= WORD_BITS'(scale_reset(RST_X_ORIGIN, FRAC_BITS));
      y_origin <= WORD_BITS'(scale_reset(RST_Y_ORIGIN, FRAC_BITS));
      x_step   <= WORD_BITS'(scale_reset(RST_X_STEP, FRAC_BITS));
      y_step   <= WORD_BITS'(scale_reset(RST_Y_STEP, FRAC_BITS));
      c_real   <= WORD_BITS'(scale_reset(RST_C_REAL, FRAC_BITS));
      c_imag   <= WORD_BITS'(scale_reset(RST_C_IMAG, FRAC_BITS));
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_ORIGIN: x_origin <= cfg_data;
        REG_Y_ORIGIN: y_origin <= cfg_data;
        REG_X_STEP:   x_step   <= cfg_data;
        REG_Y_STEP:   y_step   <= cfg_data;
        REG_C_REAL:   c_real   <= cfg_data;
        REG_C_IMAG:   c_imag   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/jets_ctrl.sv
// ----------------------------------------------------------------------------
// jets_ctrl
// Sequencer: coordinate mapping, then square / update pairs until escape or
// the iteration limit, then one result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module jets_ctrl
  import jets_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire status_t  status,
  output cmd_t          cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MAP_MUL = 6'b000010,
    S_MAP_ADD = 6'b000100,
    S_SQUARE  = 6'b001000,
    S_UPDATE  = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MAP_MUL;
        end
      end
      S_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = S_MAP_ADD;
      end
      S_MAP_ADD: begin
        cmd.map_add = 1'b1;
        state_next  = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.step = !status.escape;
        if (status.escape || status.last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SQUARE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

`default_nettype wire

>>> design/jets_dpath.sv
// ----------------------------------------------------------------------------
// jets_dpath
// Datapath: pixel latch, coordinate mapping multipliers, one complex
// square-add unit with saturation, iteration counter and level lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module jets_dpath
  import jets_pkg::*;
#(
  parameter int MAX_ITER   = 32,
  parameter int FRAC_BITS  = 20,
  parameter int COORD_BITS = 12,
  parameter int WORD_BITS  = FRAC_BITS + 4,
  parameter int CNT_W      = $clog2(MAX_ITER + 1)
) (
  input  wire logic                       clk,
  input  wire cmd_t                       cmd,
  output status_t                         status,
  input  wire logic [PIX_W-1:0]           column,
  input  wire logic [PIX_W-1:0]           row,
  input  wire logic signed [WORD_BITS-1:0] x_origin,
  input  wire logic signed [WORD_BITS-1:0] y_origin,
  input  wire logic signed [WORD_BITS-1:0] x_step,
  input  wire logic signed [WORD_BITS-1:0] y_step,
  input  wire logic signed [WORD_BITS-1:0] c_real,
  input  wire logic signed [WORD_BITS-1:0] c_imag,
  output logic [PIX_W-1:0]                pixel_column,
  output logic [PIX_W-1:0]                pixel_row,
  output logic [ITER_W-1:0]               iterations,
  output level_t                          level
);

  localparam int PW   = 2 * WORD_BITS;
  localparam int MW   = WORD_BITS + COORD_BITS + 1;
  localparam int SATW = (MW + 1 > PW + 1) ? MW + 1 : PW + 1;
  localparam logic [PW-1:0] FOUR = PW'(1) << (2 * FRAC_BITS + 2);

  logic [PIX_W-1:0]           pix_col, pix_row;
  logic signed [MW-1:0]       prod_x, prod_y;
  logic signed [MW:0]         sum_x, sum_y;
  logic signed [WORD_BITS-1:0] re, im;
  logic signed [PW-1:0]       rr, ii, ri;
  logic [PW-1:0]              mag;
  logic signed [PW:0]         nr_sum, ni_sum, nr_fl, ni_fl;
  logic signed [WORD_BITS-1:0] re_next, im_next;
  logic [CNT_W-1:0]           cnt;

  // clamp to the signed word range
  function automatic logic signed [WORD_BITS-1:0] sat_word(
    input logic signed [SATW-1:0] v
  );
    logic [SATW-WORD_BITS:0] top;
    top = v[SATW-1:WORD_BITS-1];
    if ((&top) || !(|top)) begin
      return v[WORD_BITS-1:0];
    end
    if (v[SATW-1]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end
    return {1'b0, {(WORD_BITS-1){1'b1}}};
  endfunction

  // pixel word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_col <= column;
      pix_row <= row;
    end
  end

  // index times step, registered
  always_ff @(posedge clk) begin
    if (cmd.map_mul) begin
      prod_x <= $signed({1'b0, COORD_BITS'(pix_col)}) * x_step;
      prod_y <= $signed({1'b0, COORD_BITS'(pix_row)}) * y_step;
    end
  end

  assign sum_x = (MW+1)'(prod_x) + (MW+1)'(x_origin);
  assign sum_y = (MW+1)'(prod_y) + (MW+1)'(y_origin);

  // square-add unit, second half: floor to the word, then clamp
  assign mag    = $unsigned(rr) + $unsigned(ii);
  assign nr_sum = (PW+1)'(rr) - (PW+1)'(ii) + ((PW+1)'(c_real) <<< FRAC_BITS);
  assign ni_sum = (PW+1)'(ri) + ((PW+1)'(c_imag) <<< (FRAC_BITS - 1));
  assign nr_fl  = nr_sum >>> FRAC_BITS;
  assign ni_fl  = ni_sum >>> (FRAC_BITS - 1);
  assign re_next = sat_word(SATW'(nr_fl));
  assign im_next = sat_word(SATW'(ni_fl));

  // z register and iteration count
  always_ff @(posedge clk) begin
    if (cmd.map_add) begin
      re  <= sat_word(SATW'(sum_x));
      im  <= sat_word(SATW'(sum_y));
      cnt <= '0;
    end else if (cmd.step) begin
      re  <= re_next;
      im  <= im_next;
      cnt <= cnt + CNT_W'(1);
    end
  end

  // square-add unit, first half: the three products
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      rr <= re * re;
      ii <= im * im;
      ri <= re * im;
    end
  end

  assign status.escape = (mag >= FOUR);
  assign status.last   = (cnt == CNT_W'(MAX_ITER - 1));

  // result word
  assign pixel_column = pix_col;
  assign pixel_row    = pix_row;
  assign iterations   = ITER_W'(cnt);
  assign level        = level_of(8'(cnt));

endmodule

`default_nettype wire

>>> design/julia_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel
// Julia set escape-time pixel: maps (column, row) to a complex start point,
// iterates z = z^2 + c and returns the count and a log-scaled level.
// ----------------------------------------------------------------------------
//  channel   handshake          fields
//  input     start / busy       column, row
//  result    done (strobe)      pixel_column, pixel_row, iterations, level
//  config    cfg_we             cfg_index, cfg_data
//
//  A word is taken when start is high and busy is low. The result strobe
//  comes after the mapping multiply and add and, for each iteration, a
//  product step and an update step on the one shared square-add unit.
//  busy drops the cycle after the strobe. rst is synchronous and restores
//  the register defaults. The receiver cannot stall: done is high for
//  exactly one cycle.
`default_nettype none

module julia_escape_time_pixel
  import jets_pkg::*;
#(
  parameter int MAX_ITER   = 32,
  parameter int FRAC_BITS  = 20,
  parameter int COORD_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [PIX_W-1:0]              column,
  input  wire logic [PIX_W-1:0]              row,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [FRAC_BITS+3:0]          cfg_data,
  output logic                               done,
  output logic [PIX_W-1:0]                   pixel_column,
  output logic [PIX_W-1:0]                   pixel_row,
  output logic [ITER_W-1:0]                  iterations,
  output level_t                             level
);

  localparam int WORD_BITS = FRAC_BITS + 4;

  cmd_t    cmd;
  status_t status;
  logic signed [WORD_BITS-1:0] x_origin, y_origin, x_step, y_step, c_real, c_imag;

  // configuration registers
  jets_cfg #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .x_origin  (x_origin),
    .y_origin  (y_origin),
    .x_step    (x_step),
    .y_step    (y_step),
    .c_real    (c_real),
    .c_imag    (c_imag)
  );

  // sequencer
  jets_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // arithmetic
  jets_dpath #(
    .MAX_ITER   (MAX_ITER),
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .column       (column),
    .row          (row),
    .x_origin     (x_origin),
    .y_origin     (y_origin),
    .x_step       (x_step),
    .y_step       (y_step),
    .c_real       (c_real),
    .c_imag       (c_imag),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .iterations   (iterations),
    .level        (level)
  );

endmodule

`default_nettype wire

>>> design/jets_checker.sv
// ----------------------------------------------------------------------------
// jets_checker
// Port-level checks of the command handshake, result strobe and count limit.
// ----------------------------------------------------------------------------
`default_nettype none

module jets_checker
  import jets_pkg::*;
#(
  parameter int MAX_ITER = 32
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [ITER_W-1:0] iterations
);

  // a taken word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("busy not raised after an accepted word");

  // strobe only while busy, one cycle wide
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy ##1 !done))
    else $error("result strobe malformed");

  // busy ends only right after a result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

  // count never passes the limit
  a_iter_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> ((MAX_ITER > 63) || (int'(iterations) <= MAX_ITER)))
    else $error("iteration count past the limit");

endmodule

bind julia_escape_time_pixel jets_checker #(
  .MAX_ITER (MAX_ITER)
) u_jets_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .iterations (iterations)
);

`default_nettype wire
